>>> rtl/shared_array_two_stacks_assert.svh
// Assertion macros shared by the two-stack block.
// Both macros sample on the rising edge of i_clk; the first one is disabled
// while the synchronous reset is held, the second one is checked always.
`ifndef SHARED_ARRAY_TWO_STACKS_ASSERT_SVH
`define SHARED_ARRAY_TWO_STACKS_ASSERT_SVH

`ifndef SYNTH

`define SAS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

`define SAS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`else

`define SAS_ASSERT(label, prop)

`define SAS_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> rtl/sas_pkg.sv
`timescale 1ns / 1ps

package sas_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DEPTH_FIELD_W = 5;

    // Request codes. The unused code behaves like a top read.
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               stack_sel;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]       top_value;
        logic [1:0]               status;
        logic                     low_stack_empty;
        logic                     high_stack_empty;
        logic                     store_full;
        logic [DEPTH_FIELD_W-1:0] low_stack_depth;
        logic [DEPTH_FIELD_W-1:0] high_stack_depth;
    } t_out_item;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage

>>> rtl/sas_ctrl.sv
`timescale 1ns / 1ps

module sas_ctrl
    import sas_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A held result leaves in the same cycle that the next request enters.
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                n_state = i_in_valid ? S_HOLD : S_IDLE;
            end
            S_HOLD: begin
                if (i_out_stall) begin
                    n_state = S_HOLD;
                end else begin
                    n_state = i_in_valid ? S_HOLD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_out_valid = 1'b0;
            end
            S_HOLD: begin
                o_in_stall  = i_out_stall;
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall  = 1'b1;
                o_out_valid = 1'b0;
            end
        endcase
        w_accept   = i_in_valid && !o_in_stall;
        o_cmd.exec = w_accept;
    end

endmodule

>>> rtl/sas_datapath.sv
`timescale 1ns / 1ps
`include "shared_array_two_stacks_assert.svh"

module sas_datapath
    import sas_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [31:0] r_mem [DEPTH];

    logic [CW-1:0]      r_low;
    logic [CW-1:0]      r_high;
    logic [CW-1:0]      n_low;
    logic [CW-1:0]      n_high;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic               r_top_zero;
    logic               r_use_push;
    logic signed [31:0] r_push_val;
    logic signed [31:0] r_rd_data;

    logic [CW:0]        w_sum;
    logic               w_full;
    logic [CW-1:0]      w_sel_cnt;
    logic               w_sel_empty;
    logic [CW-1:0]      w_new_sel_cnt;
    logic               w_push_ok;
    logic               w_exec_push;
    logic [AW-1:0]      w_addr;

    assign w_sum       = {1'b0, r_low} + {1'b0, r_high};
    assign w_full      = (w_sum >= (CW + 1)'(DEPTH));
    assign w_sel_cnt   = i_item.stack_sel ? r_high : r_low;
    assign w_sel_empty = (w_sel_cnt == '0);
    assign w_push_ok   = (i_item.req_type == REQ_PUSH) && !w_full;
    assign w_exec_push = i_cmd.exec && w_push_ok;

    always_comb begin
        n_low    = r_low;
        n_high   = r_high;
        n_status = STAT_OK;
        unique case (i_item.req_type)
            REQ_PUSH: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else if (i_item.stack_sel) begin
                    n_high = r_high + CW'(1);
                end else begin
                    n_low = r_low + CW'(1);
                end
            end
            REQ_POP: begin
                if (w_sel_empty) begin
                    n_status = STAT_EMPTY;
                end else if (i_item.stack_sel) begin
                    n_high = r_high - CW'(1);
                end else begin
                    n_low = r_low - CW'(1);
                end
            end
            default: begin
                if (w_sel_empty) begin
                    n_status = STAT_EMPTY;
                end
            end
        endcase
    end

    // The new top of the selected stack; for a push it is also the slot written.
    assign w_new_sel_cnt = i_item.stack_sel ? n_high : n_low;
    assign w_addr = i_item.stack_sel ? AW'(CW'(DEPTH) - n_high) : AW'(n_low - CW'(1));

    always_ff @(posedge i_clk) begin
        if (w_exec_push) begin
            r_mem[w_addr] <= i_item.push_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else if (i_cmd.exec) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_top_zero <= (w_new_sel_cnt == '0);
            r_use_push <= w_push_ok;
            r_push_val <= i_item.push_value;
        end
    end

    // A word just pushed bypasses the store read, which returns the old entry.
    assign o_item.top_value        = r_top_zero ? 32'sd0 : (r_use_push ? r_push_val : r_rd_data);
    assign o_item.status           = r_status;
    assign o_item.low_stack_empty  = (r_low == '0);
    assign o_item.high_stack_empty = (r_high == '0);
    assign o_item.store_full       = w_full;
    assign o_item.low_stack_depth  = DEPTH_FIELD_W'(r_low);
    assign o_item.high_stack_depth = DEPTH_FIELD_W'(r_high);

    `SAS_ASSERT(a_sum_in_range, (int'(r_low) + int'(r_high)) <= DEPTH)
    `SAS_ASSERT(a_idle_holds_counts, !i_cmd.exec |=> $stable({r_low, r_high}))
    `SAS_ASSERT(a_low_push_grows, w_exec_push && !i_item.stack_sel |=> r_low == $past(r_low) + CW'(1))
    `SAS_ASSERT(a_high_push_grows, w_exec_push && i_item.stack_sel |=> r_high == $past(r_high) + CW'(1))
    `SAS_ASSERT_ALWAYS(a_bypass_not_empty, (i_rst_n && $past(i_rst_n) && r_use_push) |-> !r_top_zero)

endmodule

>>> rtl/shared_array_two_stacks.sv
`timescale 1ns / 1ps
// Two stacks in one store of DEPTH signed 32-bit words. The low stack grows
// upward from entry 0 and the high stack grows downward from entry DEPTH-1.
// Request channel: i_in_valid / o_in_stall carry one transaction of type
// t_in_item (push, pop or top read, plus the stack select and push word).
// Result channel: o_out_valid / i_out_stall carry one t_out_item per
// request: the selected stack's top after the request (0 when empty), a
// status code, both empty flags, the full flag and both depths.
// A request accepted at one edge has its result valid in the following cycle.
// The store is read synchronously at the address of the new top during the
// accept cycle, so one request is in flight at a time; a new request is taken
// in the same cycle that the previous result is taken, which gives one
// transaction per cycle with an idle receiver.
// While the receiver stalls, the result register holds and the request side
// stalls too. Reset (synchronous, active low) empties both stacks at once;
// the store itself is not cleared, since only pushed entries reach the result.
// An unused request code behaves as a top read.

module shared_array_two_stacks
    import sas_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd w_cmd;

    // The controller sequences the handshakes and issues one execute per request.
    sas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the counters, the shared store and the result register.
    sas_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_in_data),
        .o_item  (o_out_data)
    );

endmodule

>>> sim/two_stacks_check.sv
`timescale 1ns / 1ps

module two_stacks_check
    import sas_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_errors,
    output int        o_pending
);

    localparam int SLOTS = DEPTH_DEFAULT;
    localparam int SHOWN_FAILURES = 10;

    // Own copy of the shared store and of both stack depths.
    logic signed [31:0] stack_words [SLOTS];
    int unsigned        low_depth;
    int unsigned        high_depth;

    t_out_item pending_results [$];
    t_out_item oldest_result;
    int        error_count;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic signed [31:0] top_word(logic sel);
        if (!sel) begin
            return (low_depth == 0) ? 32'sd0 : stack_words[low_depth - 1];
        end
        return (high_depth == 0) ? 32'sd0 : stack_words[SLOTS - high_depth];
    endfunction

    // Applies one request to the local state and returns its result.
    function automatic t_out_item apply_request(t_in_item rq);
        t_out_item res;
        logic      was_full;
        logic      sel_empty;
        res       = '0;
        was_full  = (low_depth + high_depth) >= SLOTS;
        sel_empty = rq.stack_sel ? (high_depth == 0) : (low_depth == 0);
        res.status = STAT_OK;
        case (rq.req_type)
            REQ_PUSH: begin
                if (was_full) begin
                    res.status = STAT_FULL;
                end else if (!rq.stack_sel) begin
                    stack_words[low_depth] = rq.push_value;
                    low_depth++;
                end else begin
                    high_depth++;
                    stack_words[SLOTS - high_depth] = rq.push_value;
                end
            end
            REQ_POP: begin
                if (sel_empty) begin
                    res.status = STAT_EMPTY;
                end else if (!rq.stack_sel) begin
                    low_depth--;
                end else begin
                    high_depth--;
                end
            end
            default: begin
                // A top read, and the spare code acts the same way.
                if (sel_empty) begin
                    res.status = STAT_EMPTY;
                end
            end
        endcase
        res.top_value        = top_word(rq.stack_sel);
        res.low_stack_empty  = (low_depth == 0);
        res.high_stack_empty = (high_depth == 0);
        res.store_full       = (low_depth + high_depth) >= SLOTS;
        res.low_stack_depth  = low_depth[DEPTH_FIELD_W-1:0];
        res.high_stack_depth = high_depth[DEPTH_FIELD_W-1:0];
        return res;
    endfunction

    function automatic string show_result(t_out_item r);
        return $sformatf("top=%0d status=%0d empty=%0b/%0b full=%0b depth=%0d/%0d",
                         r.top_value, r.status, r.low_stack_empty, r.high_stack_empty,
                         r.store_full, r.low_stack_depth, r.high_stack_depth);
    endfunction

    function automatic logic fields_differ(t_out_item want, t_out_item got);
        return (want.top_value !== got.top_value)
            || (want.status !== got.status)
            || (want.low_stack_empty !== got.low_stack_empty)
            || (want.high_stack_empty !== got.high_stack_empty)
            || (want.store_full !== got.store_full)
            || (want.low_stack_depth !== got.low_stack_depth)
            || (want.high_stack_depth !== got.high_stack_depth);
    endfunction

    task automatic note_failure(string want_text, string got_text);
        error_count++;
        if (error_count <= SHOWN_FAILURES) begin
            $display("mismatch at %0t: expected %s, got %s", $realtime, want_text, got_text);
        end
    endtask

    // The result is checked before the request of the same edge is applied,
    // since that result always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            low_depth  = 0;
            high_depth = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    note_failure("no result", show_result(i_out_data));
                end else begin
                    oldest_result = pending_results.pop_front();
                    if (fields_differ(oldest_result, i_out_data)) begin
                        note_failure(show_result(oldest_result), show_result(i_out_data));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(apply_request(i_in_data));
            end
        end
        o_errors  <= error_count;
        o_pending <= pending_results.size();
    end

    initial begin
        error_count = 0;
        low_depth   = 0;
        high_depth  = 0;
    end

endmodule

>>> sim/shared_array_two_stacks_tb.sv
`timescale 1ns / 1ps

module shared_array_two_stacks_tb;
    import sas_pkg::*;

    // The request code that the block treats as a top read.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int RANDOM_REQUESTS = 850;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 10;
    // The slowest correct run stays well under this limit, even
    // with the longest sender gaps and receiver stalls piled on each other.
    localparam int CYCLE_LIMIT     = 300000;

    // Burst flavors for the random part.
    localparam int BURST_FILL  = 0;
    localparam int BURST_DRAIN = 1;
    localparam int BURST_MIXED = 2;
    localparam int BURST_NOISE = 3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int error_total;
    int results_open;
    int cycle_count = 0;

    // Receiver stall pattern state.
    int stall_left = 0;
    int calm_left  = 0;
    int stall_pick;

    always #6 clk = ~clk;

    shared_array_two_stacks dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // The checker watches both channels, keeps its own model of the two
    // stacks, and reports how many results went wrong and how many are
    // still outstanding.
    two_stacks_check stack_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (error_total),
        .o_pending   (results_open)
    );

    // Watchdog. A hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver side. Stalls come in random runs, mostly short and sometimes
    // long, and between them calm stretches of varying length so that some
    // traffic flows with no back pressure at all.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (calm_left > 0) begin
            calm_left--;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 45) begin
                calm_left = $urandom_range(0, 6);
            end else if (stall_pick < 55) begin
                calm_left = $urandom_range(20, 80);
            end else if (stall_pick < 92) begin
                stall_left = $urandom_range(1, 3);
            end else begin
                stall_left = $urandom_range(8, 30);
            end
        end
        out_stall <= (stall_left > 0);
    end

    function automatic t_in_item make_request(logic [1:0] kind, logic sel,
                                              logic signed [31:0] word);
        t_in_item rq;
        rq.req_type   = kind;
        rq.stack_sel  = sel;
        rq.push_value = word;
        return rq;
    endfunction

    // Idle time on the request side: usually none or a little, rarely long.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    // Presents one request and holds it until the block takes it. Valid is
    // only dropped when a gap follows, so it is never lowered and raised at
    // the same edge. The payload stays put while the block stalls.
    task automatic issue_request(input t_in_item rq, input bit rush);
        int gap;
        gap = rush ? 0 : idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        do begin
            @(posedge clk);
        end while (in_stall);
    endtask

    // Mostly random words, with the signed extremes, zero and all ones
    // mixed in now and then.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    // One random request shaped by the burst flavor. Fill bursts push the
    // store to full and then keep pushing into it; drain bursts empty a
    // stack and keep popping it; noise bursts use any code at all.
    function automatic t_in_item random_request(int flavor, int sel_bias);
        int         pick;
        logic [1:0] kind;
        logic       sel;
        pick = $urandom_range(0, 99);
        case (flavor)
            BURST_FILL: begin
                kind = (pick < 80) ? REQ_PUSH : (pick < 90) ? REQ_READ :
                       (pick < 95) ? REQ_POP : REQ_SPARE;
            end
            BURST_DRAIN: begin
                kind = (pick < 75) ? REQ_POP : (pick < 85) ? REQ_PUSH :
                       (pick < 95) ? REQ_READ : REQ_SPARE;
            end
            BURST_MIXED: begin
                kind = (pick < 40) ? REQ_PUSH : (pick < 75) ? REQ_POP :
                       (pick < 95) ? REQ_READ : REQ_SPARE;
            end
            default: begin
                kind = 2'($urandom_range(0, 3));
            end
        endcase
        // A bias of 0 or 1 favors that stack; 2 picks either evenly.
        if (sel_bias == 2) begin
            sel = 1'($urandom_range(0, 1));
        end else begin
            sel = ($urandom_range(0, 9) == 0) ? !sel_bias[0] : sel_bias[0];
        end
        return make_request(kind, sel, pick_word());
    endfunction

    initial begin
        int issued;
        int burst_len;
        int flavor;
        int sel_bias;
        bit rush;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty refusals, the spare code, extreme words on
        // both stacks, pops that leave a stack empty, and push words given
        // along with pops and reads where they must be ignored.
        issue_request(make_request(REQ_READ,  1'b0, 32'sd0), 1'b0);
        issue_request(make_request(REQ_POP,   1'b1, 32'sd0), 1'b0);
        issue_request(make_request(REQ_SPARE, 1'b0, 32'sd0), 1'b1);
        issue_request(make_request(REQ_PUSH,  1'b0, 32'sh7FFF_FFFF), 1'b1);
        issue_request(make_request(REQ_PUSH,  1'b0, 32'sh8000_0000), 1'b1);
        issue_request(make_request(REQ_READ,  1'b0, 32'sd0), 1'b0);
        issue_request(make_request(REQ_SPARE, 1'b0, 32'sh1234_5678), 1'b0);
        issue_request(make_request(REQ_PUSH,  1'b1, -32'sd1), 1'b1);
        issue_request(make_request(REQ_PUSH,  1'b1, 32'sd0), 1'b1);
        issue_request(make_request(REQ_READ,  1'b1, 32'sd0), 1'b1);
        issue_request(make_request(REQ_POP,   1'b1, 32'sd0), 1'b0);
        issue_request(make_request(REQ_POP,   1'b1, 32'sd0), 1'b0);
        issue_request(make_request(REQ_POP,   1'b1, 32'sd0), 1'b1);
        issue_request(make_request(REQ_POP,   1'b0, 32'sd0), 1'b0);
        issue_request(make_request(REQ_POP,   1'b0, 32'sd0), 1'b1);
        issue_request(make_request(REQ_PUSH,  1'b1, 32'sh5555_5555), 1'b0);
        issue_request(make_request(REQ_PUSH,  1'b0, 32'shAAAA_AAAA), 1'b1);
        issue_request(make_request(REQ_READ,  1'b1, -32'sd1), 1'b1);
        issue_request(make_request(REQ_POP,   1'b0, 32'sh7FFF_FFFF), 1'b0);
        issue_request(make_request(REQ_POP,   1'b1, 32'sh8000_0000), 1'b1);

        // Random part in bursts. Each burst has a flavor, a stack bias and
        // sometimes no idle time at all on the request side.
        issued = 0;
        while (issued < RANDOM_REQUESTS) begin
            flavor    = $urandom_range(0, 9);
            flavor    = (flavor < 4) ? BURST_FILL : (flavor < 7) ? BURST_DRAIN :
                        (flavor < 9) ? BURST_MIXED : BURST_NOISE;
            sel_bias  = $urandom_range(0, 2);
            rush      = ($urandom_range(0, 4) == 0);
            burst_len = $urandom_range(5, 30);
            repeat (burst_len) begin
                issue_request(random_request(flavor, sel_bias), rush);
                issued++;
            end
        end
        in_valid <= 1'b0;

        // Let every outstanding result come out, then let the block run on for
        // SETTLE_CYCLES in case it produces anything it should not.
        do begin
            @(posedge clk);
        end while (results_open != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_total == 0 && results_open == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
